// ===== hdl/p2g_pkg.sv =====
// ----------------------------------------------------------------------------
// p2g_pkg
// Shared types and constants of the point to grid and repulsion block.
// ----------------------------------------------------------------------------
package p2g_pkg;

	localparam int unsigned UNIT_W   = 64;
	localparam int unsigned GRID_MAX = 1024;

	// Register indexes on the configuration port (byte address is four times this).
	localparam logic [2:0] REG_CELL_SIZE = 3'd0;
	localparam logic [2:0] REG_GRID      = 3'd1;
	localparam logic [2:0] REG_H_LOW     = 3'd2;
	localparam logic [2:0] REG_H_HIGH    = 3'd3;
	localparam logic [2:0] REG_RADIUS    = 3'd4;
	localparam logic [2:0] REG_GAIN      = 3'd5;

	localparam logic [9:0]  RST_CELL_SIZE = 10'd50;
	localparam logic [10:0] RST_GRID      = 11'd50;
	localparam logic [15:0] RST_H_LOW     = 16'd100;
	localparam logic [15:0] RST_H_HIGH    = 16'd1000;
	localparam logic [14:0] RST_RADIUS    = 15'd400;
	localparam logic [15:0] RST_GAIN      = 16'd128;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} unit_op_t;

	typedef struct packed {
		logic             start;
		unit_op_t         op;
		logic [UNIT_W-1:0] opa;
		logic [UNIT_W-1:0] opb;
	} unit_req_t;

	typedef struct packed {
		logic              done;
		logic [UNIT_W-1:0] result;
	} unit_rsp_t;

endpackage

// ===== hdl/p2g_unit.sv =====
// ----------------------------------------------------------------------------
// p2g_unit
// Shared iterative unit: shift-add multiply, restoring divide, integer root.
// ----------------------------------------------------------------------------
module p2g_unit
	import p2g_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  unit_req_t req,
	output unit_rsp_t rsp
);

	localparam logic [UNIT_W-1:0] SQRT_TOP = {2'b01, {(UNIT_W-2){1'b0}}};

	logic              busy_q;
	unit_op_t          op_q;
	logic [UNIT_W-1:0] a_q;
	logic [UNIT_W-1:0] b_q;
	logic [UNIT_W-1:0] acc_q;
	logic [UNIT_W:0]   rem_q;
	logic [6:0]        cnt_q;
	logic              finish;
	logic [UNIT_W:0]   rem_sh;
	logic [UNIT_W-1:0] root_sum;

	always_comb begin
		rem_sh   = {rem_q[UNIT_W-1:0], a_q[UNIT_W-1]};
		root_sum = acc_q + b_q;
		case (op_q)
			OP_MUL:  finish = (b_q == '0);
			OP_DIV:  finish = (cnt_q == 7'(UNIT_W));
			OP_SQRT: finish = (b_q == '0);
			default: finish = 1'b1;
		endcase
	end

	assign rsp = {busy_q & finish,
		(op_q == OP_MUL) ? acc_q : (op_q == OP_DIV) ? a_q : acc_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q   <= OP_MUL;
		end else if (req.start) begin
			busy_q <= 1'b1;
			op_q   <= req.op;
		end else if (busy_q && finish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.opa;
			acc_q <= '0;
			rem_q <= '0;
			cnt_q <= '0;
			b_q   <= (req.op == OP_SQRT) ? SQRT_TOP : req.opb;
			// For the root the operand lives in rem_q, the partial root in acc_q.
			if (req.op == OP_SQRT)
				rem_q <= {1'b0, req.opa};
		end else if (busy_q && !finish) begin
			case (op_q)
				OP_MUL: begin
					if (b_q[0])
						acc_q <= acc_q + a_q;
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				OP_DIV: begin
					if (rem_sh >= {1'b0, b_q}) begin
						rem_q <= rem_sh - {1'b0, b_q};
						a_q   <= {a_q[UNIT_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						a_q   <= {a_q[UNIT_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 7'd1;
				end
				OP_SQRT: begin
					if (rem_q[UNIT_W-1:0] >= root_sum) begin
						rem_q <= {1'b0, rem_q[UNIT_W-1:0] - root_sum};
						acc_q <= (acc_q >> 1) + b_q;
					end else begin
						acc_q <= acc_q >> 1;
					end
					b_q <= b_q >> 2;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

// ===== hdl/point_to_grid_with_repulsion_unit.sv =====
// ----------------------------------------------------------------------------
// point_to_grid_with_repulsion_unit
// Maps height-filtered points to a square grid and sums repulsive forces.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake          Content
//  s_*       in    s_tvalid/s_tready  x_mm, y_mm, z_mm; s_tlast = last_point
//  m_*       out   m_tvalid/m_tready  cell_index, force_x, force_y; tuser = cell_hit
//  p*        in    APB, pready high   six configuration registers at 4*i
//
// A kept point adds two grid divides, one per axis. A point inside the radius adds
// a root, six divides and five shift-add multiplies. All of these run on the
// shared unit, one after another. The block takes one item at a time; a waiting
// result holds the sequencer in its last step only.
// Reset clears the sums and loads the register defaults.
// ----------------------------------------------------------------------------
module point_to_grid_with_repulsion_unit
	import p2g_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_mm [15:0], y_mm [31:16], z_mm [47:32]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // cell_index [19:0], force_x [51:20], force_y [83:52]
	output logic        m_tuser,   // cell_hit
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'd1 << 0,
		S_PREP  = 21'd1 << 1,
		S_PREP2 = 21'd1 << 2,
		S_GX    = 21'd1 << 3,
		S_GY    = 21'd1 << 4,
		S_GIDX  = 21'd1 << 5,
		S_FCHK  = 21'd1 << 6,
		S_SQRT  = 21'd1 << 7,
		S_DIVA  = 21'd1 << 8,
		S_DIVB  = 21'd1 << 9,
		S_GQ    = 21'd1 << 10,
		S_M1K   = 21'd1 << 11,
		S_DT    = 21'd1 << 12,
		S_M256  = 21'd1 << 13,
		S_DF    = 21'd1 << 14,
		S_MX    = 21'd1 << 15,
		S_DX    = 21'd1 << 16,
		S_MY    = 21'd1 << 17,
		S_DY    = 21'd1 << 18,
		S_ACC   = 21'd1 << 19,
		S_OUT   = 21'd1 << 20
	} state_t;

	state_t state_q;

	logic [9:0]  cell_size_q;
	logic [10:0] grid_cells_q;
	logic [15:0] h_low_q;
	logic [15:0] h_high_q;
	logic [14:0] radius_q;
	logic [15:0] gain_q;

	logic signed [15:0] x_q, y_q;
	logic               last_q, kept_q;
	logic [10:0]        g_q;
	logic [19:0]        gc_q;
	logic signed [21:0] numx_q, numy_q;
	logic [19:0]        qx_q, qy_q;
	logic [31:0]        d2_q;
	logic [29:0]        rr_q;
	logic               hit_q;
	logic [19:0]        idx_q;
	logic [23:0]        d8_q;
	logic [20:0]        a_q, b_q;
	logic [UNIT_W-1:0]  w_q, f_q, vx_q, vy_q;
	logic signed [31:0] sum_x_q, sum_y_q;
	logic               run_q;

	logic               out_valid_q;
	logic [19:0]        out_idx_q;
	logic               out_hit_q, out_last_q;
	logic signed [31:0] out_fx_q, out_fy_q;

	unit_req_t req;
	unit_rsp_t rsp;

	logic               cfg_wr;
	logic signed [15:0] in_x, in_y, in_z;
	logic [10:0]        g_eff;
	logic [16:0]        abs_x, abs_y;
	logic [20:0]        inv;
	logic               unit_state;
	logic               inx, iny;
	logic [10:0]        gxv, gyv;
	logic [21:0]        idx_prod;
	logic signed [33:0] comp_x, comp_y, nsum_x, nsum_y;
	logic signed [31:0] sat_x, sat_y;

	p2g_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q  <= RST_CELL_SIZE;
			grid_cells_q <= RST_GRID;
			h_low_q      <= RST_H_LOW;
			h_high_q     <= RST_H_HIGH;
			radius_q     <= RST_RADIUS;
			gain_q       <= RST_GAIN;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_CELL_SIZE: cell_size_q  <= pwdata[9:0];
				REG_GRID:      grid_cells_q <= pwdata[10:0];
				REG_H_LOW:     h_low_q      <= pwdata[15:0];
				REG_H_HIGH:    h_high_q     <= pwdata[15:0];
				REG_RADIUS:    radius_q     <= pwdata[14:0];
				REG_GAIN:      gain_q       <= pwdata[15:0];
				default:       gain_q       <= gain_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_CELL_SIZE: prdata = {22'd0, cell_size_q};
			REG_GRID:      prdata = {21'd0, grid_cells_q};
			REG_H_LOW:     prdata = {16'd0, h_low_q};
			REG_H_HIGH:    prdata = {16'd0, h_high_q};
			REG_RADIUS:    prdata = {17'd0, radius_q};
			REG_GAIN:      prdata = {16'd0, gain_q};
			default:       prdata = 32'd0;
		endcase
	end

	// ---------------- datapath helpers ----------------
	assign in_x  = s_tdata[15:0];
	assign in_y  = s_tdata[31:16];
	assign in_z  = s_tdata[47:32];
	assign g_eff = (grid_cells_q > 11'(GRID_MAX)) ? 11'(GRID_MAX) : grid_cells_q;
	assign abs_x = x_q[15] ? 17'(-{x_q[15], x_q}) : {1'b0, x_q};
	assign abs_y = y_q[15] ? 17'(-{y_q[15], y_q}) : {1'b0, y_q};
	assign inv   = (a_q > b_q) ? (a_q - b_q) : 21'd0;

	// A negative numerator truncates to cell 0 only while it is under one cell.
	assign inx      = numx_q[21] ? (qx_q == 20'd0) : (qx_q < 20'(g_q));
	assign iny      = numy_q[21] ? (qy_q == 20'd0) : (qy_q < 20'(g_q));
	assign gxv      = numx_q[21] ? 11'd0 : qx_q[10:0];
	assign gyv      = numy_q[21] ? 11'd0 : qy_q[10:0];
	assign idx_prod = gyv * g_q;

	always_comb begin
		comp_x = (vx_q > 64'h8000_0000) ? 34'sh0_8000_0000 : {2'b00, vx_q[31:0]};
		comp_y = (vy_q > 64'h8000_0000) ? 34'sh0_8000_0000 : {2'b00, vy_q[31:0]};
		if (!x_q[15])
			comp_x = -comp_x;
		if (!y_q[15])
			comp_y = -comp_y;
		nsum_x = 34'(sum_x_q) + comp_x;
		nsum_y = 34'(sum_y_q) + comp_y;
		if (nsum_x > 34'sh0_7FFF_FFFF)
			sat_x = 32'sh7FFF_FFFF;
		else if (nsum_x < -34'sh0_8000_0000)
			sat_x = 32'sh8000_0000;
		else
			sat_x = nsum_x[31:0];
		if (nsum_y > 34'sh0_7FFF_FFFF)
			sat_y = 32'sh7FFF_FFFF;
		else if (nsum_y < -34'sh0_8000_0000)
			sat_y = 32'sh8000_0000;
		else
			sat_y = nsum_y[31:0];
	end

	// ---------------- shared unit requests ----------------
	always_comb begin
		case (state_q)
			S_GX, S_GY, S_SQRT, S_DIVA, S_DIVB, S_GQ, S_M1K, S_DT, S_M256, S_DF,
			S_MX, S_DX, S_MY, S_DY: unit_state = 1'b1;
			default:                unit_state = 1'b0;
		endcase
	end

	always_comb begin
		req.start = unit_state & ~run_q;
		req.op    = OP_DIV;
		req.opa   = '0;
		req.opb   = '0;
		case (state_q)
			S_GX: begin
				req.opa = numx_q[21] ? UNIT_W'(-numx_q) : UNIT_W'(numx_q);
				req.opb = UNIT_W'({cell_size_q, 1'b0});
			end
			S_GY: begin
				req.opa = numy_q[21] ? UNIT_W'(-numy_q) : UNIT_W'(numy_q);
				req.opb = UNIT_W'({cell_size_q, 1'b0});
			end
			S_SQRT: begin
				req.op  = OP_SQRT;
				req.opa = UNIT_W'({d2_q, 16'd0});
			end
			S_DIVA: begin
				req.opa = UNIT_W'(64'd1000 << 24);
				req.opb = UNIT_W'(d8_q);
			end
			S_DIVB: begin
				req.opa = UNIT_W'(64'd1000 << 16);
				req.opb = UNIT_W'(radius_q);
			end
			S_GQ: begin
				req.op  = OP_MUL;
				req.opa = UNIT_W'(inv);
				req.opb = UNIT_W'(gain_q);
			end
			S_M1K: begin
				req.op  = OP_MUL;
				req.opa = w_q;
				req.opb = UNIT_W'(1000);
			end
			S_DT, S_DF: begin
				req.opa = w_q;
				req.opb = UNIT_W'(d8_q);
			end
			S_M256: begin
				req.op  = OP_MUL;
				req.opa = w_q;
				req.opb = UNIT_W'(256000);
			end
			S_MX: begin
				req.op  = OP_MUL;
				req.opa = f_q;
				req.opb = UNIT_W'(abs_x);
			end
			S_MY: begin
				req.op  = OP_MUL;
				req.opa = f_q;
				req.opb = UNIT_W'(abs_y);
			end
			S_DX, S_DY: begin
				req.opa = w_q << 8;
				req.opb = UNIT_W'(d8_q);
			end
			default: begin
				req.op = OP_DIV;
			end
		endcase
	end

	// ---------------- sequencer ----------------
	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			run_q       <= 1'b0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the output step the valid flag is handled there.
			if (m_tready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			if (req.start)
				run_q <= 1'b1;
			if (rsp.done)
				run_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_PREP;
				end
				S_PREP:  state_q <= S_PREP2;
				S_PREP2: begin
					if (kept_q && g_q != 11'd0 && cell_size_q != 10'd0)
						state_q <= S_GX;
					else
						state_q <= S_FCHK;
				end
				S_GX:   if (rsp.done) state_q <= S_GY;
				S_GY:   if (rsp.done) state_q <= S_GIDX;
				S_GIDX: state_q <= S_FCHK;
				S_FCHK: begin
					if (kept_q && d2_q > 32'd2500 && d2_q < 32'(rr_q))
						state_q <= S_SQRT;
					else
						state_q <= S_OUT;
				end
				S_SQRT: if (rsp.done) state_q <= S_DIVA;
				S_DIVA: if (rsp.done) state_q <= S_DIVB;
				S_DIVB: if (rsp.done) state_q <= S_GQ;
				S_GQ:   if (rsp.done) state_q <= S_M1K;
				S_M1K:  if (rsp.done) state_q <= S_DT;
				S_DT:   if (rsp.done) state_q <= S_M256;
				S_M256: if (rsp.done) state_q <= S_DF;
				S_DF:   if (rsp.done) state_q <= S_MX;
				S_MX:   if (rsp.done) state_q <= S_DX;
				S_DX:   if (rsp.done) state_q <= S_MY;
				S_MY:   if (rsp.done) state_q <= S_DY;
				S_DY:   if (rsp.done) state_q <= S_ACC;
				S_ACC: begin
					sum_x_q <= sat_x;
					sum_y_q <= sat_y;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						if (last_q) begin
							sum_x_q <= '0;
							sum_y_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q    <= in_x;
				y_q    <= in_y;
				last_q <= s_tlast;
				kept_q <= (in_z >= $signed(h_low_q)) && (in_z <= $signed(h_high_q));
				hit_q  <= 1'b0;
				idx_q  <= '0;
			end
			S_PREP: begin
				g_q  <= g_eff;
				gc_q <= 20'(g_eff * cell_size_q);
				d2_q <= $unsigned(32'(x_q) * 32'(x_q));
			end
			S_PREP2: begin
				numx_q <= {{5{x_q[15]}}, x_q, 1'b0} + {2'b00, gc_q};
				numy_q <= {{5{y_q[15]}}, y_q, 1'b0} + {2'b00, gc_q};
				d2_q   <= d2_q + $unsigned(32'(y_q) * 32'(y_q));
				rr_q   <= radius_q * radius_q;
			end
			S_GX: if (rsp.done) qx_q <= rsp.result[19:0];
			S_GY: if (rsp.done) qy_q <= rsp.result[19:0];
			S_GIDX: begin
				hit_q <= inx & iny;
				idx_q <= (inx & iny) ? 20'(idx_prod + 22'(gxv)) : 20'd0;
			end
			S_SQRT: if (rsp.done) d8_q <= rsp.result[23:0];
			S_DIVA: if (rsp.done) a_q <= rsp.result[20:0];
			S_DIVB: if (rsp.done) b_q <= rsp.result[20:0];
			S_GQ, S_M1K, S_DT, S_M256, S_MX, S_MY: if (rsp.done) w_q <= rsp.result;
			S_DF: if (rsp.done) f_q <= rsp.result;
			S_DX: if (rsp.done) vx_q <= rsp.result;
			S_DY: if (rsp.done) vy_q <= rsp.result;
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_idx_q  <= idx_q;
					out_hit_q  <= hit_q;
					out_last_q <= last_q;
					out_fx_q   <= sum_x_q;
					out_fy_q   <= sum_y_q;
				end
			end
			default: begin
				w_q <= w_q;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_fy_q, out_fx_q, out_idx_q};
	assign m_tuser  = out_hit_q;
	assign m_tlast  = out_last_q;

endmodule
